/* sv/srpb_pkg.sv */
// Shared definitions for the sparse row pattern builder.
// Field widths, command and status codes, and the controller/datapath interface structs.
// No dependencies.
package srpb_pkg;

    // Field widths fixed by the interface.
    localparam int CMD_W      = 2;
    localparam int ROW_NUM_W  = 10;
    localparam int COL_W      = 10;
    localparam int SLOT_W     = 5;
    localparam int STATUS_W   = 3;
    localparam int RW_W       = 6;
    localparam int CNT_W      = 11;
    localparam int CAP_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Row numbers on the port cannot address more rows than this.
    localparam int ROW_SPACE = 2 ** ROW_NUM_W;
    // Capacity register cannot express more columns per row than this.
    localparam int CAP_SPACE = (2 ** CAP_W) - 1;

    // Default sizing.
    localparam int MAX_ROWS_DEF  = 1024;
    localparam int MAX_WIDTH_DEF = 32;

    // Register reset values.
    localparam int ROW_COUNT_RST = 1024;
    localparam int ROW_CAP_RST   = 32;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_CAP   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NOP    = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_OUT_RANGE = 3'd3,
        ST_DONE      = 3'd4
    } t_status;

    // Which kind of result the datapath should assemble.
    typedef enum logic [2:0] {
        RES_OUT_RANGE,
        RES_BLANK,
        RES_READ,
        RES_DUPLICATE,
        RES_OVERFLOW,
        RES_INSERTED
    } t_res_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      load;
        logic      lookup;
        logic      take_w;
        logic      seed;
        logic      scan_start;
        logic      scan_step;
        logic      append;
        logic      clr_step;
        logic      res_load;
        t_res_kind res_kind;
        logic      out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_cmd cmd;
        logic row_ok;
        logic w_zero;
        logic hit;
        logic scan_done;
        logic full;
        logic clr_last;
    } t_dp_sts;

endpackage

/* sv/srpb_dp.sv */
// Datapath of the sparse row pattern builder: item and config registers, the width and
// column memories, the scan comparator, and the result and output registers.
// Depends on srpb_pkg.
module srpb_dp
    import srpb_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ROW_NUM_W-1:0]  i_row_number,
    input  logic [COL_W-1:0]      i_column_number,
    input  logic [SLOT_W-1:0]     i_slot_number,
    input  t_dp_cmd               i_ctl,
    output t_dp_sts               o_sts,
    output logic [STATUS_W-1:0]   o_status,
    output logic [RW_W-1:0]       o_row_width,
    output logic [COL_W-1:0]      o_column_value,
    output logic                  o_slot_valid
);

    localparam int USED_ROWS  = (MAX_ROWS < ROW_SPACE) ? MAX_ROWS : ROW_SPACE;
    localparam int USED_WIDTH = (MAX_WIDTH < CAP_SPACE) ? MAX_WIDTH : CAP_SPACE;
    localparam int ROW_AW     = $clog2(USED_ROWS);
    localparam int SLOT_AW    = $clog2(USED_WIDTH);
    localparam int WW         = $clog2(USED_WIDTH + 1);
    localparam int CAW        = ROW_AW + SLOT_AW;
    localparam int CDEPTH     = USED_ROWS * (2 ** SLOT_AW);
    localparam int CMP_W      = ($clog2(MAX_WIDTH + 1) > CAP_W) ? $clog2(MAX_WIDTH + 1) : CAP_W;
    localparam int RCMP_W     = ($clog2(MAX_ROWS + 1) > CNT_W) ? $clog2(MAX_ROWS + 1) : CNT_W;

    // Item registers.
    t_cmd                 r_cmd;
    logic [ROW_NUM_W-1:0] r_row;
    logic [COL_W-1:0]     r_col;
    logic [SLOT_W-1:0]    r_slot;

    // Configuration.
    logic [CNT_W-1:0] r_row_count;
    logic [CAP_W-1:0] r_row_cap;

    // Memories and their read registers.
    logic [WW-1:0]    r_wmem [USED_ROWS];
    logic [COL_W-1:0] r_cmem [CDEPTH];
    logic [WW-1:0]    r_wq;
    logic [COL_W-1:0] r_colq;

    // Scan state.
    logic [WW-1:0]     r_w;
    logic [WW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [ROW_AW-1:0] r_clr_idx;

    // Result stage and output registers.
    t_status          r_res_status;
    logic [RW_W-1:0]  r_res_width;
    logic [COL_W-1:0] r_res_value;
    logic             r_res_ok;
    t_status          r_out_status;
    logic [RW_W-1:0]  r_out_width;
    logic [COL_W-1:0] r_out_value;
    logic             r_out_ok;

    logic [ROW_AW-1:0] row_a;
    logic [WW-1:0]     w_inc;
    logic              issue_more;
    logic              slot_ok;
    logic              clr_last;
    logic [CMP_W-1:0]  cap_x;
    logic [CMP_W-1:0]  cap_eff;
    logic              wmem_we;
    logic [ROW_AW-1:0] wmem_waddr;
    logic [WW-1:0]     wmem_wdata;
    logic              cmem_we;
    logic [CAW-1:0]    cmem_waddr;
    logic [COL_W-1:0]  cmem_wdata;
    logic              cmem_re;
    logic [CAW-1:0]    cmem_raddr;

    assign row_a      = ROW_AW'(r_row);
    assign w_inc      = r_w + WW'(1);
    assign issue_more = r_idx < r_w;
    assign slot_ok    = RW_W'(r_slot) < RW_W'(r_wq);
    assign clr_last   = r_clr_idx == ROW_AW'(USED_ROWS - 1);

    // A capacity of zero behaves as one; anything above the storage depth is clipped.
    assign cap_x   = CMP_W'(r_row_cap);
    assign cap_eff = (cap_x == '0) ? CMP_W'(1)
                   : ((cap_x > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : cap_x);

    assign o_sts.cmd       = r_cmd;
    assign o_sts.row_ok    = (RCMP_W'(r_row) < RCMP_W'(r_row_count))
                          && (RCMP_W'(r_row) < RCMP_W'(MAX_ROWS));
    assign o_sts.w_zero    = r_wq == '0;
    assign o_sts.hit       = r_cmp_vld && (r_colq == r_col);
    assign o_sts.scan_done = !issue_more && !r_cmp_vld;
    assign o_sts.full      = CMP_W'(r_w) >= cap_eff;
    assign o_sts.clr_last  = clr_last;

    // Width memory write port: clearing sweep, diagonal seed, or append.
    always_comb begin
        wmem_we    = i_ctl.clr_step || i_ctl.seed || i_ctl.append;
        wmem_waddr = i_ctl.clr_step ? r_clr_idx : row_a;
        if (i_ctl.clr_step) begin
            wmem_wdata = '0;
        end else if (i_ctl.seed) begin
            wmem_wdata = WW'(1);
        end else begin
            wmem_wdata = w_inc;
        end
    end

    // Column memory ports.
    always_comb begin
        cmem_we    = i_ctl.seed || i_ctl.append;
        cmem_waddr = i_ctl.seed ? {row_a, SLOT_AW'(0)} : {row_a, r_w[SLOT_AW-1:0]};
        cmem_wdata = i_ctl.seed ? COL_W'(r_row) : r_col;
        cmem_re    = i_ctl.lookup || (i_ctl.scan_step && issue_more);
        cmem_raddr = i_ctl.lookup ? {row_a, SLOT_AW'(r_slot)} : {row_a, r_idx[SLOT_AW-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (wmem_we) begin
            r_wmem[wmem_waddr] <= wmem_wdata;
        end
        if (i_ctl.lookup) begin
            r_wq <= r_wmem[row_a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmem_we) begin
            r_cmem[cmem_waddr] <= cmem_wdata;
        end
        if (cmem_re) begin
            r_colq <= r_cmem[cmem_raddr];
        end
    end

    // Control-like registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= CNT_W'(ROW_COUNT_RST);
            r_row_cap   <= CAP_W'(ROW_CAP_RST);
            r_cmp_vld   <= 1'b0;
            r_clr_idx   <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_ROW_COUNT: r_row_count <= i_cfg_data[CNT_W-1:0];
                    REG_ROW_CAP:   r_row_cap   <= i_cfg_data[CAP_W-1:0];
                    default:       r_row_cap   <= r_row_cap;
                endcase
            end
            r_cmp_vld <= i_ctl.scan_step && issue_more;
            if (i_ctl.clr_step) begin
                r_clr_idx <= clr_last ? '0 : r_clr_idx + ROW_AW'(1);
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_row  <= i_row_number;
            r_col  <= i_column_number;
            r_slot <= i_slot_number;
        end
        if (i_ctl.take_w) begin
            r_w <= (r_wq == '0) ? WW'(1) : r_wq;
        end
        if (i_ctl.scan_start) begin
            r_idx <= '0;
        end else if (i_ctl.scan_step && issue_more) begin
            r_idx <= r_idx + WW'(1);
        end
        if (i_ctl.res_load) begin
            case (i_ctl.res_kind)
                RES_OUT_RANGE: begin
                    r_res_status <= ST_OUT_RANGE;
                    r_res_width  <= '0;
                    r_res_value  <= '0;
                    r_res_ok     <= 1'b0;
                end
                RES_READ: begin
                    r_res_status <= ST_DONE;
                    r_res_width  <= RW_W'(r_wq);
                    r_res_value  <= slot_ok ? r_colq : '0;
                    r_res_ok     <= slot_ok;
                end
                RES_DUPLICATE: begin
                    r_res_status <= ST_DUPLICATE;
                    r_res_width  <= RW_W'(r_w);
                    r_res_value  <= '0;
                    r_res_ok     <= 1'b0;
                end
                RES_OVERFLOW: begin
                    r_res_status <= ST_OVERFLOW;
                    r_res_width  <= RW_W'(r_w);
                    r_res_value  <= '0;
                    r_res_ok     <= 1'b0;
                end
                RES_INSERTED: begin
                    r_res_status <= ST_INSERTED;
                    r_res_width  <= RW_W'(w_inc);
                    r_res_value  <= '0;
                    r_res_ok     <= 1'b0;
                end
                default: begin
                    r_res_status <= ST_DONE;
                    r_res_width  <= '0;
                    r_res_value  <= '0;
                    r_res_ok     <= 1'b0;
                end
            endcase
        end
        if (i_ctl.out_load) begin
            r_out_status <= r_res_status;
            r_out_width  <= r_res_width;
            r_out_value  <= r_res_value;
            r_out_ok     <= r_res_ok;
        end
    end

    assign o_status       = r_out_status;
    assign o_row_width    = r_out_width;
    assign o_column_value = r_out_value;
    assign o_slot_valid   = r_out_ok;

endmodule

/* sv/srpb_ctrl.sv */
// Controller of the sparse row pattern builder: sequences lookup, scan, append and clearing.
// Depends on srpb_pkg; drives srpb_dp through t_dp_cmd and reads t_dp_sts.
module srpb_ctrl
    import srpb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_dp_cmd o_ctl
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_LOOK,
        S_DECIDE,
        S_SCAN,
        S_CLEAR,
        S_HOLD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_ctl    = '0;
        n_state  = r_state;
        case (r_state)
            S_INIT: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                case (i_sts.cmd)
                    CMD_CLEAR: begin
                        n_state = S_CLEAR;
                    end
                    CMD_NOP: begin
                        o_ctl.res_load = 1'b1;
                        o_ctl.res_kind = RES_BLANK;
                        n_state        = S_HOLD;
                    end
                    default: begin
                        if (!i_sts.row_ok) begin
                            o_ctl.res_load = 1'b1;
                            o_ctl.res_kind = RES_OUT_RANGE;
                            n_state        = S_HOLD;
                        end else begin
                            o_ctl.lookup = 1'b1;
                            n_state      = S_DECIDE;
                        end
                    end
                endcase
            end
            S_DECIDE: begin
                if (i_sts.cmd == CMD_READ) begin
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_kind = RES_READ;
                    n_state        = S_HOLD;
                end else begin
                    o_ctl.take_w     = 1'b1;
                    o_ctl.seed       = i_sts.w_zero;
                    o_ctl.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.hit) begin
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_kind = RES_DUPLICATE;
                    n_state        = S_HOLD;
                end else if (i_sts.scan_done) begin
                    o_ctl.res_load = 1'b1;
                    n_state        = S_HOLD;
                    if (i_sts.full) begin
                        o_ctl.res_kind = RES_OVERFLOW;
                    end else begin
                        o_ctl.append   = 1'b1;
                        o_ctl.res_kind = RES_INSERTED;
                    end
                end
            end
            S_CLEAR: begin
                o_ctl.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    o_ctl.res_load = 1'b1;
                    o_ctl.res_kind = RES_BLANK;
                    n_state        = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_ctl.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = o_ctl.out_load ? 1'b1 : (r_out_valid && i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

endmodule

/* sv/sparse_row_pattern_builder.sv */
// Top level of the sparse row pattern builder.
// Joins the controller srpb_ctrl and the datapath srpb_dp; depends on srpb_pkg.
//
// The block keeps, for every row of a sparse matrix, a list of connected column numbers
// and the row's width. Each input beat carries a command: insert a (row, column) pair,
// read one slot of a row, clear all rows, or do nothing; every beat gives exactly one
// result beat. An insert into an empty row stores the row's own diagonal first, then
// scans the stored columns one per cycle out of the column memory and appends the new
// column only if it is absent and the row is below the configured capacity. The block
// works on one beat at a time. The scan reads through the single read port of the column
// memory, and a duplicate ends it early. Clearing is a sweep of the width memory over
// min(MAX_ROWS, 1024) rows, one row per cycle; the same sweep runs after reset, and
// input beats are stalled until it completes (configuration writes are taken
// throughout). A result beat waits in the output register while the next input beat is
// accepted and worked on; the next result is held back for as long as the waiting one
// stays stalled. Configuration is written through a plain write port (index 0 row count,
// index 1 row capacity) and must only be changed while the block is idle. Stored columns
// are not initialised, but only slots below a row's width are ever returned.
module sparse_row_pattern_builder
    import srpb_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ROW_NUM_W-1:0]  i_row_number,
    input  logic [COL_W-1:0]      i_column_number,
    input  logic [SLOT_W-1:0]     i_slot_number,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [STATUS_W-1:0]   o_status,
    output logic [RW_W-1:0]       o_row_width,
    output logic [COL_W-1:0]      o_column_value,
    output logic                  o_slot_valid
);

    t_dp_cmd ctl;
    t_dp_sts sts;

    // Sequencing of each beat: lookup, scan, append, clear sweep and result hand-off.
    srpb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctl       (ctl)
    );

    // Storage, comparison and result formatting.
    srpb_dp #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (i_cmd),
        .i_row_number    (i_row_number),
        .i_column_number (i_column_number),
        .i_slot_number   (i_slot_number),
        .i_ctl           (ctl),
        .o_sts           (sts),
        .o_status        (o_status),
        .o_row_width     (o_row_width),
        .o_column_value  (o_column_value),
        .o_slot_valid    (o_slot_valid)
    );

endmodule

/* sv/srpb_checker.sv */
// Port-level checks for the sparse row pattern builder, bound to the top level.
// Depends on srpb_pkg and on the port names of sparse_row_pattern_builder.
module srpb_checker
    import srpb_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [STATUS_W-1:0]   o_status,
    input logic [RW_W-1:0]       o_row_width,
    input logic [COL_W-1:0]      o_column_value,
    input logic                  o_slot_valid
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat withdrawn while stalled");

    // A stalled result beat keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_status) && $stable(o_row_width)
            && $stable(o_column_value) && $stable(o_slot_valid))
        else $error("result payload changed while stalled");

    // A successful insert always follows the diagonal, so the row holds at least two columns.
    a_insert_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_INSERTED) |-> o_row_width >= RW_W'(2))
        else $error("insert reported with width below two");

    // A valid slot only comes from a read of a non-empty row.
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_slot_valid |-> (o_status == ST_DONE) && (o_row_width != '0))
        else $error("slot valid on a non-read or empty row");

    // An out-of-range row reports nothing else.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OUT_RANGE)
            |-> (o_row_width == '0) && (o_column_value == '0) && !o_slot_valid)
        else $error("out-of-range result carries data");

endmodule

bind sparse_row_pattern_builder srpb_checker u_srpb_checker (.*);

/* tb/srpb_pattern_checker.sv */
`timescale 1ns / 1ps
// Result checker for the sparse row pattern builder testbench.
// Watches the configuration port and both beat channels, keeps its own row pattern
// state to work out each result, and compares what comes out. Depends on srpb_pkg.
module srpb_pattern_checker
    import srpb_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [CMD_W-1:0]      i_cmd,
    input  logic [ROW_NUM_W-1:0]  i_row_number,
    input  logic [COL_W-1:0]      i_column_number,
    input  logic [SLOT_W-1:0]     i_slot_number,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [STATUS_W-1:0]   i_status,
    input  logic [RW_W-1:0]       i_row_width,
    input  logic [COL_W-1:0]      i_column_value,
    input  logic                  i_slot_valid,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        t_status              status;
        logic [RW_W-1:0]      width;
        logic [COL_W-1:0]     column;
        logic                 valid;
    } t_row_result;

    // Own copy of the pattern: stored columns, row widths and both registers.
    logic [COL_W-1:0]  stored_cols [MAX_ROWS*MAX_WIDTH];
    logic [RW_W-1:0]   row_fill [MAX_ROWS];
    logic [CNT_W-1:0]  rows_reg;
    logic [CAP_W-1:0]  cap_reg;

    t_row_result awaited_results [$];
    int          fail_n;

    // Works out the result of one input beat and updates the pattern.
    function automatic t_row_result apply_pattern_beat(
        input logic [CMD_W-1:0]     cmd,
        input logic [ROW_NUM_W-1:0] row,
        input logic [COL_W-1:0]     col,
        input logic [SLOT_W-1:0]    slot
    );
        t_row_result res;
        int unsigned rows_eff;
        int unsigned cap_eff;
        int unsigned w;
        int unsigned base;
        int unsigned n;
        res = '0;
        res.status = ST_DONE;
        if (cmd == CMD_CLEAR) begin
            for (n = 0; n < MAX_ROWS; n++) row_fill[n] = '0;
            return res;
        end
        if (cmd == CMD_NOP) return res;
        rows_eff = (rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg;
        if (row >= rows_eff) begin
            res.status = ST_OUT_RANGE;
            return res;
        end
        base = row * MAX_WIDTH;
        w = row_fill[row];
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (cmd == CMD_READ) begin
            res.width = RW_W'(w);
            if (slot < w) begin
                res.column = stored_cols[base + slot];
                res.valid  = 1'b1;
            end
            return res;
        end
        // An empty row gets its diagonal before anything else.
        if (w == 0) begin
            stored_cols[base] = COL_W'(row);
            w = 1;
            row_fill[row] = RW_W'(1);
        end
        res.width = RW_W'(w);
        for (n = 0; n < w; n++) begin
            if (stored_cols[base + n] == col) begin
                res.status = ST_DUPLICATE;
                return res;
            end
        end
        cap_eff = (cap_reg == 0) ? 1 : ((cap_reg > MAX_WIDTH) ? MAX_WIDTH : cap_reg);
        if (w >= cap_eff) begin
            res.status = ST_OVERFLOW;
            return res;
        end
        stored_cols[base + w] = col;
        w++;
        row_fill[row] = RW_W'(w);
        res.status = ST_INSERTED;
        res.width  = RW_W'(w);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_row_result want;
        int          n;
        if (!i_rst_n) begin
            for (n = 0; n < MAX_ROWS; n++) row_fill[n] = '0;
            rows_reg = CNT_W'(ROW_COUNT_RST);
            cap_reg  = CAP_W'(ROW_CAP_RST);
            awaited_results.delete();
            fail_n = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ROW_COUNT) rows_reg = i_cfg_data[CNT_W-1:0];
                else if (i_cfg_index == REG_ROW_CAP) cap_reg = i_cfg_data[CAP_W-1:0];
            end
            // Output first, so a stray beat cannot consume an expectation pushed this cycle.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    fail_n++;
                    if (fail_n <= 10)
                        $display("%0t: result error: unexpected beat status %0d width %0d",
                                 $time, i_status, i_row_width);
                end else begin
                    want = awaited_results.pop_front();
                    if (want.status !== i_status || want.width !== i_row_width ||
                        want.column !== i_column_value || want.valid !== i_slot_valid) begin
                        fail_n++;
                        if (fail_n <= 10)
                            $display("%0t: result error: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $time, want.status, want.width, want.column,
                                     want.valid, i_status, i_row_width, i_column_value,
                                     i_slot_valid);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(apply_pattern_beat(i_cmd, i_row_number,
                                                             i_column_number, i_slot_number));
        end
        o_fail_count <= fail_n;
        o_pending    <= awaited_results.size();
    end

endmodule

/* tb/sparse_row_pattern_builder_test.sv */
`timescale 1ns / 1ps
// Top of the sparse row pattern builder testbench: clock, reset, stimulus and verdict.
// Instantiates sparse_row_pattern_builder and srpb_pattern_checker; depends on srpb_pkg.
module sparse_row_pattern_builder_test;
    import srpb_pkg::*;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic [CMD_W-1:0]      i_cmd = '0;
    logic [ROW_NUM_W-1:0]  i_row_number = '0;
    logic [COL_W-1:0]      i_column_number = '0;
    logic [SLOT_W-1:0]     i_slot_number = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [STATUS_W-1:0]   o_status;
    logic [RW_W-1:0]       o_row_width;
    logic [COL_W-1:0]      o_column_value;
    logic                  o_slot_valid;

    int fail_count;
    int pending;

    // Idling percentages for the two sides, changed from one phase to the next.
    int sender_pct = 0;
    int stall_pct  = 0;

    // Register values last written, and the few rows that the random beats aim at.
    int cur_rows = ROW_COUNT_RST;
    int cur_cap  = ROW_CAP_RST;
    int hot_base = 0;
    int hot_n    = 1;

    // Random phases: row count, row capacity and number of beats. The settings run from
    // the largest values the registers hold down to zero, where the capacity acts as one
    // and no row is in range at all.
    int phase_rows  [10] = '{16, 2, 2047, 12, 5, 1, 0, 1023, 64, 1024};
    int phase_cap   [10] = '{32, 32, 63, 8, 3, 1, 0, 17, 0, 32};
    int phase_beats [10] = '{130, 200, 120, 130, 120, 60, 40, 120, 60, 50};

    sparse_row_pattern_builder uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_row_number    (i_row_number),
        .i_column_number (i_column_number),
        .i_slot_number   (i_slot_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_row_width     (o_row_width),
        .o_column_value  (o_column_value),
        .o_slot_valid    (o_slot_valid)
    );

    srpb_pattern_checker pattern_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_row_number    (i_row_number),
        .i_column_number (i_column_number),
        .i_slot_number   (i_slot_number),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_status        (o_status),
        .i_row_width     (o_row_width),
        .i_column_value  (o_column_value),
        .i_slot_valid    (o_slot_valid),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The receiving side stalls at random with the phase's percentage; at zero it never does.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Offers one beat, after a random gap when the sender idles, and returns at the edge
    // that accepts it. Valid is left high so that back-to-back beats need no second write.
    task automatic send_beat(
        input logic [CMD_W-1:0]     cmd,
        input logic [ROW_NUM_W-1:0] row,
        input logic [COL_W-1:0]     col,
        input logic [SLOT_W-1:0]    slot
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_pct) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_cmd           <= cmd;
        i_row_number    <= row;
        i_column_number <= col;
        i_slot_number   <= slot;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Holds the sender back until every awaited result has come out. The bound covers a
    // clear sweep with a stalling receiver many times over; if it runs out, the verdict
    // sees the results still pending.
    task automatic drain_results();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
    endtask

    // Writes the row count register and then the capacity register; only called with the block idle.
    task automatic set_config(input int rows, input int cap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_ROW_COUNT;
        i_cfg_data  <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_index <= REG_ROW_CAP;
        i_cfg_data  <= CFG_DATA_W'(cap);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_rows = rows;
        cur_cap  = cap;
    endtask

    // Idling patterns: none, sender only, receiver only, then both at a lighter rate.
    task automatic set_idling(input int mode);
        case (mode)
            1: begin
                sender_pct = 47;
                stall_pct  = 0;
            end
            2: begin
                sender_pct = 0;
                stall_pct  = 47;
            end
            3: begin
                sender_pct = 16;
                stall_pct  = 16;
            end
            default: begin
                sender_pct = 0;
                stall_pct  = 0;
            end
        endcase
    endtask

    // One random beat. Most beats go to a handful of rows in range, with columns close
    // to those rows, so that duplicates, diagonals and full rows come up often. The rest
    // use fully random fields, so every bit of every field sees both values, and rows
    // deliberately out of range.
    task automatic random_beat();
        int                   pick;
        int                   act_rows;
        int                   cap_eff;
        logic [CMD_W-1:0]     cmd;
        logic [ROW_NUM_W-1:0] row;
        logic [COL_W-1:0]     col;
        logic [SLOT_W-1:0]    slot;
        act_rows = (cur_rows > ROW_SPACE) ? ROW_SPACE : cur_rows;
        cap_eff  = (cur_cap < 1) ? 1 : ((cur_cap > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cur_cap);
        pick = $urandom_range(999);
        if (pick < 600) cmd = CMD_INSERT;
        else if (pick < 940) cmd = CMD_READ;
        else if (pick < 992) cmd = CMD_NOP;
        else cmd = CMD_CLEAR;
        pick = $urandom_range(99);
        if (pick < 8 || act_rows == 0) row = ROW_NUM_W'($urandom);
        else if (pick < 14 && act_rows < ROW_SPACE)
            row = ROW_NUM_W'($urandom_range(ROW_SPACE - 1, act_rows));
        else row = ROW_NUM_W'(hot_base + $urandom_range(hot_n - 1));
        pick = $urandom_range(99);
        if (pick < 10) col = COL_W'($urandom);
        else if (pick < 25) col = row;
        else col = COL_W'(hot_base + $urandom_range(cap_eff + 6));
        if ($urandom_range(99) < 30) slot = SLOT_W'($urandom);
        else slot = SLOT_W'($urandom_range((cap_eff > 31) ? 31 : cap_eff));
        send_beat(cmd, row, col, slot);
    endtask

    initial begin
        int ph;
        int act_rows;
        set_idling(0);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed beats on the reset settings. The block stalls its input during the
        // clearing sweep after reset, which the handshake absorbs.
        send_beat(CMD_READ,   10'd0,    10'd0,    5'd0);   // empty row reads width zero
        send_beat(CMD_INSERT, 10'd5,    10'd5,    5'd0);   // diagonal into empty row
        send_beat(CMD_INSERT, 10'd5,    10'd1023, 5'd0);
        send_beat(CMD_INSERT, 10'd5,    10'd1023, 5'd0);   // duplicate
        send_beat(CMD_INSERT, 10'd1023, 10'd0,    5'd0);   // top row, column zero
        send_beat(CMD_READ,   10'd1023, 10'd0,    5'd0);
        send_beat(CMD_READ,   10'd1023, 10'd0,    5'd1);
        send_beat(CMD_READ,   10'd1023, 10'd0,    5'd31);  // slot beyond the width
        send_beat(CMD_INSERT, 10'd0,    10'h2AA,  5'd0);
        send_beat(CMD_INSERT, 10'd0,    10'h155,  5'd0);
        send_beat(CMD_NOP,    10'd1023, 10'h3FF,  5'd31);  // unused command
        send_beat(CMD_READ,   10'd0,    10'd0,    5'd2);
        drain_results();

        // Capacity below widths already stored: row 0 holds three columns.
        set_config(4, 2);
        send_beat(CMD_INSERT, 10'd0,    10'd7,    5'd0);   // full row, dropped
        send_beat(CMD_INSERT, 10'd0,    10'h155,  5'd0);   // duplicate wins over full
        send_beat(CMD_READ,   10'd1023, 10'd0,    5'd0);   // read out of range
        send_beat(CMD_INSERT, 10'd4,    10'd1,    5'd0);   // insert out of range
        send_beat(CMD_INSERT, 10'd3,    10'd1,    5'd0);
        send_beat(CMD_INSERT, 10'd3,    10'd2,    5'd0);
        drain_results();

        // A capacity of zero behaves as one: only the diagonal fits.
        set_config(4, 0);
        send_beat(CMD_INSERT, 10'd2,    10'd9,    5'd0);
        send_beat(CMD_INSERT, 10'd1,    10'd1,    5'd0);
        drain_results();

        set_config(1024, 32);
        send_beat(CMD_CLEAR,  10'h3FF,  10'h3FF,  5'd31);  // row number is ignored
        send_beat(CMD_READ,   10'd5,    10'd0,    5'd0);
        send_beat(CMD_INSERT, 10'd1023, 10'd1023, 5'd0);

        // Random phases. Each one starts from an idle block, which also gives the sender
        // a pause until every awaited result has come.
        for (ph = 0; ph < 10; ph++) begin
            drain_results();
            set_config(phase_rows[ph], phase_cap[ph]);
            set_idling(ph % 4);
            act_rows = (cur_rows > ROW_SPACE) ? ROW_SPACE : cur_rows;
            hot_n    = (act_rows < 4) ? act_rows : 4;
            if (hot_n < 1) hot_n = 1;
            hot_base = (act_rows > hot_n) ? $urandom_range(act_rows - hot_n) : 0;
            repeat (phase_beats[ph]) random_beat();
        end

        // Let the last results out, then leave room for a late clear sweep to show up.
        drain_results();
        repeat (1100) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this, even if every beat were a clear.
    initial begin
        #40_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
